### src/urf_pkg.sv
// Shared types and constants for the UDP frame receive filter.
package urf_pkg;

  localparam int unsigned IdxW          = 11;
  localparam int unsigned MaxFrame      = 1600;
  localparam int unsigned IpHeaderBytes = 20;
  localparam int unsigned PayloadStart  = 42;
  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned TypeHiOffset  = 12;
  localparam int unsigned ProtoOffset   = 23;
  localparam int unsigned HdrEnd        = EthHdrBytes + IpHeaderBytes;
  localparam logic [IdxW-1:0] IndexMax  = {IdxW{1'b1}};

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [15:0] EthertypeReset = 16'h0800;
  localparam logic [7:0]  UdpProtoReset  = 8'h11;

  // register index, taken from paddr[2]
  localparam logic RegEthertype = 1'b0;
  localparam logic RegUdpProto  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RX_ERROR  = 3'd1,
    ST_RUNT      = 3'd2,
    ST_NON_IP    = 3'd3,
    ST_BAD_CSUM  = 3'd4,
    ST_NON_UDP   = 3'd5,
    ST_UDP_SHORT = 3'd6
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] ip_ethertype;
    logic [7:0]  udp_protocol;
  } cfg_t;

  // one classified input byte, as queued between parser and emitter
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_char;
    logic        has_status;
    status_e     status;
    logic [31:0] frames_seen;
  } rec_t;

endpackage

### src/udp_frame_receive_filter_top.sv
// Top level of the UDP frame receive filter: APB registers, parser, queue, emitter.
// Takes one frame byte per cycle on the slave stream; the parser classifies each byte in
// the cycle it arrives and a four-entry queue decouples it from the output. Each result
// leaves through an output register at one transfer per cycle while m_axis_tready is high,
// so a final byte that also carries payload costs a payload transfer and a status transfer;
// the input keeps running at one byte per cycle while the queue has room, and the sustained
// rate is set by the output port at one result per cycle.
module udp_frame_receive_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] rx_error
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_char, [10:8] frame_status,
                                      // [42:11] frames_seen, [47:43] zero
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast
);

  urf_pkg::cfg_t cfg_q, cfg_d;
  urf_pkg::rec_t push_rec, head_rec;
  logic          wr_en;
  logic          accept;
  logic          push, full, pop, empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        urf_pkg::RegEthertype: cfg_d.ip_ethertype = pwdata[15:0];
        urf_pkg::RegUdpProto:  cfg_d.udp_protocol = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      urf_pkg::RegEthertype: prdata = {16'h0000, cfg_q.ip_ethertype};
      urf_pkg::RegUdpProto:  prdata = {24'h000000, cfg_q.udp_protocol};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ip_ethertype <= urf_pkg::EthertypeReset;
      cfg_q.udp_protocol <= urf_pkg::UdpProtoReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  urf_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .err_i    (s_axis_tuser),
    .push_o   (push),
    .rec_o    (push_rec)
  );

  urf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_rec),
    .empty_o (empty)
  );

  urf_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_rec),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### src/urf_parser.sv
// Front end: tracks frame position, header checks and checksum, classifies each byte.
module urf_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  urf_pkg::cfg_t      cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic               err_i,
  output logic               push_o,
  output urf_pkg::rec_t      rec_o
);

  localparam int unsigned W = urf_pkg::IdxW;

  logic [W-1:0]  idx_q, idx_d;
  logic [16:0]   acc_q, acc_d;
  logic [7:0]    type_hi_q, type_hi_d;
  logic          is_ip_q, is_ip_d;
  logic          is_udp_q, is_udp_d;
  logic          done_q, done_d;
  logic [31:0]   count_q, count_d;

  logic [W-1:0]  rel;
  logic [15:0]   word;
  logic [16:0]   sum;
  logic          emit_pl;
  logic          sum_ok;
  urf_pkg::status_e st;

  always_comb begin
    idx_d     = idx_q;
    acc_d     = acc_q;
    type_hi_d = type_hi_q;
    is_ip_d   = is_ip_q;
    is_udp_d  = is_udp_q;
    done_d    = done_q;
    count_d   = count_q;
    emit_pl   = 1'b0;
    rel       = idx_q - W'(urf_pkg::EthHdrBytes);
    word      = rel[0] ? {8'h00, byte_i} : {byte_i, 8'h00};
    sum       = {1'b0, acc_q[15:0]} + {1'b0, word};

    if (idx_q == W'(urf_pkg::TypeHiOffset)) begin
      type_hi_d = byte_i;
    end else if (idx_q == W'(urf_pkg::TypeHiOffset + 1)) begin
      is_ip_d = {type_hi_q, byte_i} == cfg_i.ip_ethertype;
    end

    if (idx_q >= W'(urf_pkg::EthHdrBytes) && idx_q < W'(urf_pkg::HdrEnd)) begin
      acc_d = {1'b0, sum[15:0]} + {16'h0000, sum[16]};
    end

    if (idx_q == W'(urf_pkg::ProtoOffset)) begin
      is_udp_d = byte_i == cfg_i.udp_protocol;
    end

    if (idx_q >= W'(urf_pkg::PayloadStart) && !done_q) begin
      if (idx_q >= W'(urf_pkg::MaxFrame - 1) || byte_i == 8'h00) begin
        done_d = 1'b1;
      end else if (is_ip_q && is_udp_q && (acc_q[15:0] == 16'hFFFF)) begin
        emit_pl = 1'b1;
      end
    end

    if (idx_q != urf_pkg::IndexMax) begin
      idx_d = idx_q + W'(1);
    end

    sum_ok = acc_d[15:0] == 16'hFFFF;
    priority if (err_i) begin
      st = urf_pkg::ST_RX_ERROR;
    end else if (idx_q < W'(urf_pkg::EthHdrBytes - 1)) begin
      st = urf_pkg::ST_RUNT;
    end else if (!is_ip_d || idx_q < W'(urf_pkg::HdrEnd - 1)) begin
      st = urf_pkg::ST_NON_IP;
    end else if (!sum_ok) begin
      st = urf_pkg::ST_BAD_CSUM;
    end else if (!is_udp_d) begin
      st = urf_pkg::ST_NON_UDP;
    end else if (idx_q < W'(urf_pkg::PayloadStart - 1)) begin
      st = urf_pkg::ST_UDP_SHORT;
    end else begin
      st = urf_pkg::ST_OK;
    end

    if (last_i) begin
      count_d   = count_q + 32'd1;
      idx_d     = '0;
      acc_d     = '0;
      type_hi_d = '0;
      is_ip_d   = 1'b0;
      is_udp_d  = 1'b0;
      done_d    = 1'b0;
    end
  end

  assign rec_o.has_payload  = emit_pl;
  assign rec_o.payload_char = byte_i;
  assign rec_o.has_status   = last_i;
  assign rec_o.status       = st;
  assign rec_o.frames_seen  = count_q + 32'd1;
  assign push_o             = accept_i && (emit_pl || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      acc_q     <= '0;
      type_hi_q <= '0;
      is_ip_q   <= 1'b0;
      is_udp_q  <= 1'b0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else if (accept_i) begin
      idx_q     <= idx_d;
      acc_q     <= acc_d;
      type_hi_q <= type_hi_d;
      is_ip_q   <= is_ip_d;
      is_udp_q  <= is_udp_d;
      done_q    <= done_d;
      count_q   <= count_d;
    end
  end

endmodule

### src/urf_fifo.sv
// Short record queue between the parser and the emitter.
module urf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  urf_pkg::rec_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output urf_pkg::rec_t data_o,
  output logic          empty_o
);

  localparam int unsigned Aw = urf_pkg::FifoAw;

  urf_pkg::rec_t mem_q [urf_pkg::FifoDepth];
  logic [Aw-1:0] wr_q, wr_d;
  logic [Aw-1:0] rd_q, rd_d;
  logic [Aw:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == (Aw+1)'(urf_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + Aw'(1) : wr_q;
    rd_d  = do_pop ? rd_q + Aw'(1) : rd_q;
    cnt_d = cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/urf_emitter.sv
// Back end: turns queued records into result transfers through an output register.
module urf_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  urf_pkg::rec_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  logic                valid_q, valid_d;
  logic                ph_q, ph_d;
  logic                load;
  urf_pkg::kind_e      kind_q, kind_d;
  logic [7:0]          char_q, char_d;
  urf_pkg::status_e    stat_q, stat_d;
  logic [31:0]         seen_q, seen_d;
  logic                last_q, last_d;

  assign load = !empty_i && (!valid_q || m_axis_tready);

  always_comb begin
    pop_o   = 1'b0;
    ph_d    = ph_q;
    valid_d = valid_q && !m_axis_tready;
    kind_d  = kind_q;
    char_d  = char_q;
    stat_d  = stat_q;
    seen_d  = seen_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      if (head_i.has_payload && !ph_q) begin
        kind_d = urf_pkg::KIND_PAYLOAD;
        char_d = head_i.payload_char;
        stat_d = urf_pkg::ST_OK;
        seen_d = '0;
        last_d = !head_i.has_status;
        if (head_i.has_status) begin
          ph_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        kind_d = urf_pkg::KIND_STATUS;
        char_d = '0;
        stat_d = head_i.status;
        seen_d = head_i.frames_seen;
        last_d = 1'b1;
        ph_d   = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ph_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    char_q <= char_d;
    stat_q <= stat_d;
    seen_q <= seen_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, seen_q, stat_q, char_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  // pending status half keeps its record at the queue head
  a_ph_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> (!empty_i && head_i.has_payload && head_i.has_status))
    else $error("status half pending without a matching head record");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_split_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !ph_q && head_i.has_payload && head_i.has_status) |=> ph_q)
    else $error("payload of a final byte not followed by its status");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == urf_pkg::KIND_STATUS) |-> last_q)
    else $error("status transfer without tlast");

endmodule
